// ----- design/round_robin_slice_scheduler_assert.svh -----
// ----------------------------------------------------------------------------
// Round-robin slice scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define RRSS_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("round_robin_slice_scheduler: same-cycle check failed");

// The condition holds in the cycle after the trigger.
`define RRSS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("round_robin_slice_scheduler: next-cycle check failed");

`endif

// ----- design/rrss_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin slice scheduler package
// Sizes, operation codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rrss_pkg;

  // Table size and derived widths.
  localparam int MAX_TASKS    = 16;
  localparam int IDX_W        = $clog2(MAX_TASKS);
  localparam int CNT_W        = $clog2(MAX_TASKS + 1);
  localparam int WALK_W       = $clog2(2 * MAX_TASKS);

  // Field widths.
  localparam int OP_W         = 2;
  localparam int BURST_W      = 16;
  localparam int ARR_W        = 24;
  localparam int TIME_W       = 32;
  localparam int TASK_INDEX_W = 4;
  localparam int ENTRY_W      = 2 * BURST_W;

  localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(4);

  // Input operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Kind of result placed in the output register.
  typedef enum logic [1:0] {
    RES_FULL,
    RES_EMPTY,
    RES_SLICE
  } res_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_SERVE,
    ST_EXEC,
    ST_TAT,
    ST_WAIT,
    ST_ADV,
    ST_RESP
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_entry;
    logic clear_all;
    logic walk_init;
    logic walk_step;
    logic scan_init;
    logic scan_step;
    logic b_here;
    logic serve;
    logic exec;
    logic tat;
    logic wait_acc;
    logic adv;
    logic out_load;
    res_e res_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic table_full;
    logic none_left;
    logic rem_nz;
    logic walk_last;
    logic scan_last;
    logic fin;
    logic out_free;
  } sts_t;

endpackage

// ----- design/rrss_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rrss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Round-robin slice scheduler controller
// Sequences loads, clears and slice runs, and steers the datapath through
// the skip walk, the fallback scan, service, accounting and the result.
// ----------------------------------------------------------------------------
module rrss_ctrl
  import rrss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] op_i,
  input  sts_t            sts_i,
  output logic            in_stall_o,
  output cmd_t            cmd_o
);

  ctrl_state_e state_q, state_d;
  res_e        res_kind_q, res_kind_d;

  // State and result-kind registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      res_kind_q <= RES_EMPTY;
    end else begin
      state_q    <= state_d;
      res_kind_q <= res_kind_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d    = state_q;
    res_kind_d = res_kind_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_LOAD: begin
              if (sts_i.table_full) begin
                res_kind_d = RES_FULL;
                state_d    = ST_RESP;
              end
            end
            OP_RUN: begin
              if (sts_i.none_left) begin
                res_kind_d = RES_EMPTY;
                state_d    = ST_RESP;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (sts_i.rem_nz) begin
          state_d = ST_SERVE;
        end else if (sts_i.walk_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.rem_nz) begin
          state_d = ST_SERVE;
        end else if (sts_i.scan_last) begin
          res_kind_d = RES_EMPTY;
          state_d    = ST_RESP;
        end
      end
      ST_SERVE: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.fin ? ST_TAT : ST_ADV;
      end
      ST_TAT: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = ST_ADV;
      end
      ST_ADV: begin
        res_kind_d = RES_SLICE;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = res_kind_q;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (op_i)
            OP_LOAD:  cmd_o.load_entry = !sts_i.table_full;
            OP_RUN:   cmd_o.walk_init  = !sts_i.none_left;
            OP_CLEAR: cmd_o.clear_all  = 1'b1;
            default:  cmd_o.clear_all  = 1'b0;
          endcase
        end
      end
      ST_WALK: begin
        if (sts_i.rem_nz) begin
          cmd_o.b_here = 1'b1;
        end else if (sts_i.walk_last) begin
          cmd_o.scan_init = 1'b1;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts_i.rem_nz) begin
          cmd_o.b_here = 1'b1;
        end else if (!sts_i.scan_last) begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_SERVE: cmd_o.serve    = 1'b1;
      ST_EXEC:  cmd_o.exec     = 1'b1;
      ST_TAT:   cmd_o.tat      = 1'b1;
      ST_WAIT:  cmd_o.wait_acc = 1'b1;
      ST_ADV:   cmd_o.adv      = 1'b1;
      ST_RESP:  cmd_o.out_load = sts_i.out_free;
      default:  in_stall_o     = 1'b1;
    endcase
  end

endmodule

// ----- design/rrss_dpath.sv -----
// ----------------------------------------------------------------------------
// Round-robin slice scheduler datapath
// Task table memories, clock and sum registers, the walk index and the
// output register, all driven by controller commands.
// ----------------------------------------------------------------------------
module rrss_dpath
  import rrss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    cfg_wr_en_i,
  input  logic [BURST_W-1:0]      cfg_wr_data_i,
  input  logic [BURST_W-1:0]      burst_time_i,
  input  logic [ARR_W-1:0]        arrival_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TASK_INDEX_W-1:0] task_index_o,
  output logic [TIME_W-1:0]       slice_start_o,
  output logic [BURST_W-1:0]      slice_length_o,
  output logic                    task_finished_o,
  output logic [TIME_W-1:0]       wait_time_o,
  output logic [TIME_W-1:0]       turnaround_time_o,
  output logic                    all_done_o,
  output logic [TIME_W-1:0]       total_wait_o,
  output logic [TIME_W-1:0]       total_turnaround_o,
  output logic                    table_full_o
);

  // Control state.
  logic [CNT_W-1:0]   task_count_q, task_count_d;
  logic [CNT_W-1:0]   tasks_left_q, tasks_left_d;
  logic [IDX_W-1:0]   cur_idx_q, cur_idx_d;
  logic [TIME_W-1:0]  clock_q, clock_d;
  logic [TIME_W-1:0]  wsum_q, wsum_d;
  logic [TIME_W-1:0]  tsum_q, tsum_d;
  logic [BURST_W-1:0] quantum_q, quantum_d;
  logic               out_valid_q, out_valid_d;

  // Working registers.
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [WALK_W-1:0]  k_q, k_d;
  logic [BURST_W-1:0] rem_q, rem_d;
  logic [BURST_W-1:0] burst_q, burst_d;
  logic [ARR_W-1:0]   arr_q, arr_d;
  logic [BURST_W-1:0] len_q, len_d;
  logic               fin_q, fin_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic [TIME_W-1:0]  tat_q, tat_d;
  logic [TIME_W-1:0]  wt_q, wt_d;

  // Output register.
  logic [TASK_INDEX_W-1:0] o_idx_q, o_idx_d;
  logic [TIME_W-1:0]       o_start_q, o_start_d;
  logic [BURST_W-1:0]      o_len_q, o_len_d;
  logic                    o_fin_q, o_fin_d;
  logic [TIME_W-1:0]       o_wt_q, o_wt_d;
  logic [TIME_W-1:0]       o_tat_q, o_tat_d;
  logic                    o_done_q, o_done_d;
  logic [TIME_W-1:0]       o_twait_q, o_twait_d;
  logic [TIME_W-1:0]       o_ttat_q, o_ttat_d;
  logic                    o_full_q, o_full_d;

  // Memory ports.
  logic               we_a, we_b;
  logic [IDX_W-1:0]   waddr_a, raddr_a, raddr_b, load_addr;
  logic [ENTRY_W-1:0] wdata_a, rdata_a;
  logic [ARR_W-1:0]   rdata_b;
  logic [BURST_W-1:0] rd_burst, rd_rem;

  // Helpers.
  logic [BURST_W-1:0] q_eff, load_burst;
  logic [CNT_W-1:0]   nxt_cnt;
  logic [IDX_W-1:0]   adv_idx;
  logic [WALK_W-1:0]  walk_limit;
  logic [TIME_W-1:0]  rd_arr_t, serve_start;
  logic               all_done;

  assign rd_burst   = rdata_a[ENTRY_W-1:BURST_W];
  assign rd_rem     = rdata_a[BURST_W-1:0];
  assign rd_arr_t   = TIME_W'(rdata_b);
  assign load_addr  = task_count_q[IDX_W-1:0];
  assign q_eff      = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
  assign load_burst = (burst_time_i == '0) ? BURST_W'(1) : burst_time_i;
  assign all_done   = (tasks_left_q == '0) && (task_count_q != '0);
  assign walk_limit = WALK_W'({task_count_q, 1'b0} - (CNT_W + 1)'(1));

  // Next slot after the current one: taken only if it exists and has arrived.
  assign nxt_cnt = CNT_W'(idx_q) + CNT_W'(1);
  always_comb begin
    adv_idx = '0;
    if (nxt_cnt < task_count_q && rd_arr_t <= clock_q) begin
      adv_idx = IDX_W'(nxt_cnt);
    end
  end

  // Slice start after any idle gap up to the task's arrival.
  assign serve_start = (clock_q < rd_arr_t) ? rd_arr_t : clock_q;

  // Status toward the controller.
  always_comb begin
    sts_o.table_full = (task_count_q >= CNT_W'(MAX_TASKS));
    sts_o.none_left  = (tasks_left_q == '0) || (task_count_q == '0);
    sts_o.rem_nz     = (rd_rem != '0);
    sts_o.walk_last  = (k_q == walk_limit);
    sts_o.scan_last  = (nxt_cnt == task_count_q);
    sts_o.fin        = fin_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Walk index and step counter; the memories read at the next index.
  always_comb begin
    idx_d = idx_q;
    k_d   = k_q;
    if (cmd_i.walk_init) begin
      idx_d = (CNT_W'(cur_idx_q) < task_count_q) ? cur_idx_q : '0;
      k_d   = '0;
    end else if (cmd_i.walk_step) begin
      idx_d = adv_idx;
      k_d   = k_q + WALK_W'(1);
    end else if (cmd_i.scan_init) begin
      idx_d = '0;
    end else if (cmd_i.scan_step) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  assign raddr_a = idx_d;
  assign raddr_b = cmd_i.b_here ? idx_d : idx_d + IDX_W'(1);

  // Table writes: a new record on load, the remaining time after a slice.
  always_comb begin
    we_a    = cmd_i.load_entry || cmd_i.exec;
    waddr_a = cmd_i.load_entry ? load_addr : idx_q;
    wdata_a = cmd_i.load_entry ? {load_burst, load_burst} : {burst_q, rem_q - len_q};
    we_b    = cmd_i.load_entry;
  end

  rrss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_ram_burst_rem (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  rrss_ram #(
    .WIDTH (ARR_W),
    .DEPTH (MAX_TASKS)
  ) u_ram_arrival (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (load_addr),
    .wdata_i (arrival_time_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Scheduler state: counts, clock, sums and quantum.
  always_comb begin
    task_count_d = task_count_q;
    tasks_left_d = tasks_left_q;
    cur_idx_d    = cur_idx_q;
    clock_d      = clock_q;
    wsum_d       = wsum_q;
    tsum_d       = tsum_q;
    quantum_d    = cfg_wr_en_i ? cfg_wr_data_i : quantum_q;
    if (cmd_i.clear_all) begin
      task_count_d = '0;
      tasks_left_d = '0;
      cur_idx_d    = '0;
      clock_d      = '0;
      wsum_d       = '0;
      tsum_d       = '0;
    end
    if (cmd_i.load_entry) begin
      task_count_d = task_count_q + CNT_W'(1);
      tasks_left_d = tasks_left_q + CNT_W'(1);
    end
    if (cmd_i.serve) begin
      clock_d = serve_start;
    end
    if (cmd_i.exec) begin
      clock_d = clock_q + TIME_W'(len_q);
      if (fin_q) begin
        tasks_left_d = tasks_left_q - CNT_W'(1);
      end
    end
    if (cmd_i.wait_acc) begin
      tsum_d = tsum_q + tat_q;
    end
    if (cmd_i.adv) begin
      cur_idx_d = adv_idx;
      if (fin_q) begin
        wsum_d = wsum_q + wt_q;
      end
    end
  end

  // Per-slice working values.
  always_comb begin
    rem_d   = rem_q;
    burst_d = burst_q;
    arr_d   = arr_q;
    len_d   = len_q;
    fin_d   = fin_q;
    start_d = start_q;
    tat_d   = tat_q;
    wt_d    = wt_q;
    if (cmd_i.serve) begin
      rem_d   = rd_rem;
      burst_d = rd_burst;
      arr_d   = rdata_b;
      fin_d   = (rd_rem <= q_eff);
      len_d   = (rd_rem <= q_eff) ? rd_rem : q_eff;
      start_d = serve_start;
    end
    if (cmd_i.tat) begin
      tat_d = clock_q - TIME_W'(arr_q);
    end
    if (cmd_i.wait_acc) begin
      wt_d = tat_q - TIME_W'(burst_q);
    end
  end

  // Output register load.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    o_idx_d     = o_idx_q;
    o_start_d   = o_start_q;
    o_len_d     = o_len_q;
    o_fin_d     = o_fin_q;
    o_wt_d      = o_wt_q;
    o_tat_d     = o_tat_q;
    o_done_d    = o_done_q;
    o_twait_d   = o_twait_q;
    o_ttat_d    = o_ttat_q;
    o_full_d    = o_full_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      o_idx_d     = '0;
      o_start_d   = '0;
      o_len_d     = '0;
      o_fin_d     = 1'b0;
      o_wt_d      = '0;
      o_tat_d     = '0;
      o_done_d    = 1'b0;
      o_twait_d   = '0;
      o_ttat_d    = '0;
      o_full_d    = 1'b0;
      case (cmd_i.res_kind)
        RES_FULL: begin
          o_full_d = 1'b1;
        end
        RES_EMPTY: begin
          o_start_d = clock_q;
          o_done_d  = all_done;
          o_twait_d = all_done ? wsum_q : '0;
          o_ttat_d  = all_done ? tsum_q : '0;
        end
        RES_SLICE: begin
          o_idx_d   = TASK_INDEX_W'(idx_q);
          o_start_d = start_q;
          o_len_d   = len_q;
          o_fin_d   = fin_q;
          o_wt_d    = fin_q ? wt_q : '0;
          o_tat_d   = fin_q ? tat_q : '0;
          o_done_d  = all_done;
          o_twait_d = all_done ? wsum_q : '0;
          o_ttat_d  = all_done ? tsum_q : '0;
        end
        default: begin
          o_full_d = 1'b0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      tasks_left_q <= '0;
      cur_idx_q    <= '0;
      clock_q      <= '0;
      wsum_q       <= '0;
      tsum_q       <= '0;
      quantum_q    <= QUANTUM_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      task_count_q <= task_count_d;
      tasks_left_q <= tasks_left_d;
      cur_idx_q    <= cur_idx_d;
      clock_q      <= clock_d;
      wsum_q       <= wsum_d;
      tsum_q       <= tsum_d;
      quantum_q    <= quantum_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    k_q       <= k_d;
    rem_q     <= rem_d;
    burst_q   <= burst_d;
    arr_q     <= arr_d;
    len_q     <= len_d;
    fin_q     <= fin_d;
    start_q   <= start_d;
    tat_q     <= tat_d;
    wt_q      <= wt_d;
    o_idx_q   <= o_idx_d;
    o_start_q <= o_start_d;
    o_len_q   <= o_len_d;
    o_fin_q   <= o_fin_d;
    o_wt_q    <= o_wt_d;
    o_tat_q   <= o_tat_d;
    o_done_q  <= o_done_d;
    o_twait_q <= o_twait_d;
    o_ttat_q  <= o_ttat_d;
    o_full_q  <= o_full_d;
  end

  assign out_valid_o        = out_valid_q;
  assign task_index_o       = o_idx_q;
  assign slice_start_o      = o_start_q;
  assign slice_length_o     = o_len_q;
  assign task_finished_o    = o_fin_q;
  assign wait_time_o        = o_wt_q;
  assign turnaround_time_o  = o_tat_q;
  assign all_done_o         = o_done_q;
  assign total_wait_o       = o_twait_q;
  assign total_turnaround_o = o_ttat_q;
  assign table_full_o       = o_full_q;

endmodule

// ----- design/round_robin_slice_scheduler.sv -----
// A load, a clear or an unused op is taken straight from the idle state. A
// run goes through the skip walk and, if needed, the fallback scan, which
// visit one table entry per cycle through the registered read port of the
// task table, followed by serve, update, accounting and index advance
// steps, one per cycle. A refused load or a run with nothing left goes
// straight to the result state. A new item is taken as soon as the result
// moves into the output register, even while that result still waits for
// transfer. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
// Round-robin slice scheduler
// Task table with time-slice service, per-task wait and turnaround reports
// and running totals; controller and datapath under one top level.
// ----------------------------------------------------------------------------
`include "round_robin_slice_scheduler_assert.svh"

module round_robin_slice_scheduler
  import rrss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_wr_en_i,
  input  logic [BURST_W-1:0]      cfg_wr_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic [BURST_W-1:0]      burst_time_i,
  input  logic [ARR_W-1:0]        arrival_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TASK_INDEX_W-1:0] task_index_o,
  output logic [TIME_W-1:0]       slice_start_o,
  output logic [BURST_W-1:0]      slice_length_o,
  output logic                    task_finished_o,
  output logic [TIME_W-1:0]       wait_time_o,
  output logic [TIME_W-1:0]       turnaround_time_o,
  output logic                    all_done_o,
  output logic [TIME_W-1:0]       total_wait_o,
  output logic [TIME_W-1:0]       total_turnaround_o,
  output logic                    table_full_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Table, timekeeping and output register.
  rrss_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wr_data_i      (cfg_wr_data_i),
    .burst_time_i       (burst_time_i),
    .arrival_time_i     (arrival_time_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .task_index_o       (task_index_o),
    .slice_start_o      (slice_start_o),
    .slice_length_o     (slice_length_o),
    .task_finished_o    (task_finished_o),
    .wait_time_o        (wait_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .all_done_o         (all_done_o),
    .total_wait_o       (total_wait_o),
    .total_turnaround_o (total_turnaround_o),
    .table_full_o       (table_full_o)
  );

  // A run request keeps the input stalled in the following cycle.
  `RRSS_ASSERT_NEXT(a_run_holds_input, in_valid_i && !in_stall_o && op_i == OP_RUN, in_stall_o)
  // A finishing slice always grants some time.
  `RRSS_ASSERT_IMPLY(a_finish_has_length, out_valid_o && task_finished_o, slice_length_o != '0)
  // A refused load carries no schedule information.
  `RRSS_ASSERT_IMPLY(a_full_is_bare, out_valid_o && table_full_o,
                     !all_done_o && slice_length_o == '0 && !task_finished_o)
  // The table write, run start, clear and result load never coincide.
  `RRSS_ASSERT_IMPLY(a_cmd_exclusive, 1'b1,
                     $onehot0({cmd.load_entry, cmd.walk_init, cmd.clear_all, cmd.out_load}))

endmodule

// ----- test/round_robin_slice_scheduler_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin slice scheduler testbench
// Drives load, run, clear and unused operations through the valid/stall input
// channel, predicts every slice report with a cycle-free scheduling model and
// compares each output transfer with the oldest predicted report. Quantum is
// rewritten between phases while the block is idle, and both channels idle
// and stall at random, with one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_test;
  import rrss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 3 * MAX_TASKS + 16;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEM_TARGET = 1900;
  localparam int MAX_REPORTED = 10;
  localparam logic [ARR_W-1:0] ARR_MAX = {ARR_W{1'b1}};

  // One slice report as seen on the output ports.
  typedef struct packed {
    logic [TASK_INDEX_W-1:0] task_index;
    logic [TIME_W-1:0]       slice_start;
    logic [BURST_W-1:0]      slice_length;
    logic                    task_finished;
    logic [TIME_W-1:0]       wait_time;
    logic [TIME_W-1:0]       turnaround_time;
    logic                    all_done;
    logic [TIME_W-1:0]       total_wait;
    logic [TIME_W-1:0]       total_turnaround;
    logic                    table_full;
  } slice_report_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_wr_en_i;
  logic [BURST_W-1:0]      cfg_wr_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         op_i;
  logic [BURST_W-1:0]      burst_time_i;
  logic [ARR_W-1:0]        arrival_time_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [TASK_INDEX_W-1:0] task_index_o;
  logic [TIME_W-1:0]       slice_start_o;
  logic [BURST_W-1:0]      slice_length_o;
  logic                    task_finished_o;
  logic [TIME_W-1:0]       wait_time_o;
  logic [TIME_W-1:0]       turnaround_time_o;
  logic                    all_done_o;
  logic [TIME_W-1:0]       total_wait_o;
  logic [TIME_W-1:0]       total_turnaround_o;
  logic                    table_full_o;

  // Scheduler model state.
  logic [BURST_W-1:0] m_burst     [MAX_TASKS];
  logic [ARR_W-1:0]   m_arrival   [MAX_TASKS];
  logic [BURST_W-1:0] m_remaining [MAX_TASKS];
  int unsigned        m_count = 0;
  int unsigned        m_left = 0;
  int unsigned        m_cursor = 0;
  logic [TIME_W-1:0]  m_clock = '0;
  logic [TIME_W-1:0]  m_wait_sum = '0;
  logic [TIME_W-1:0]  m_tat_sum = '0;
  logic [BURST_W-1:0] m_quantum = QUANTUM_RESET;

  // Predicted reports waiting for their output transfer.
  slice_report_t pending_reports [$];

  // Run statistics and pacing knobs.
  int unsigned items_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned mismatches = 0;
  int unsigned slices_granted = 0;
  int unsigned tasks_completed = 0;
  int unsigned refused_loads = 0;
  int unsigned empty_runs = 0;
  int unsigned quantum_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_max = 4;
  int unsigned stall_max = 4;
  int unsigned hold_request = 0;

  round_robin_slice_scheduler dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wr_data_i      (cfg_wr_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .burst_time_i       (burst_time_i),
    .arrival_time_i     (arrival_time_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .task_index_o       (task_index_o),
    .slice_start_o      (slice_start_o),
    .slice_length_o     (slice_length_o),
    .task_finished_o    (task_finished_o),
    .wait_time_o        (wait_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .all_done_o         (all_done_o),
    .total_wait_o       (total_wait_o),
    .total_turnaround_o (total_turnaround_o),
    .table_full_o       (table_full_o)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // The index after a slice moves on only if the next task has arrived.
  function automatic int unsigned next_slot(input int unsigned slot);
    if (slot + 1 >= m_count) return 0;
    if (TIME_W'(m_arrival[slot + 1]) <= m_clock) return slot + 1;
    return 0;
  endfunction

  // Apply one accepted item to the model and produce its report, if any.
  task automatic schedule_model(input logic [OP_W-1:0] op, input logic [BURST_W-1:0] burst,
                                input logic [ARR_W-1:0] arrival, output bit has_report,
                                output slice_report_t rep);
    int unsigned slot;
    int unsigned k;
    bit found;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    rep = '0;
    has_report = 1'b0;
    found = 1'b0;
    case (op)
      OP_LOAD: begin
        if (m_count >= MAX_TASKS) begin
          rep.table_full = 1'b1;
          has_report = 1'b1;
          refused_loads++;
        end else begin
          // A zero burst is stored as one time unit.
          m_burst[m_count] = (burst == '0) ? BURST_W'(1) : burst;
          m_remaining[m_count] = m_burst[m_count];
          m_arrival[m_count] = arrival;
          m_count++;
          m_left++;
        end
      end
      OP_CLEAR: begin
        m_count = 0;
        m_left = 0;
        m_cursor = 0;
        m_clock = '0;
        m_wait_sum = '0;
        m_tat_sum = '0;
      end
      OP_RUN: begin
        has_report = 1'b1;
        if (m_left == 0 || m_count == 0) begin
          rep.slice_start = m_clock;
          empty_runs++;
        end else begin
          // Skip walk from the current index, then the lowest unfinished slot.
          slot = (m_cursor >= m_count) ? 0 : m_cursor;
          for (k = 0; k < 2 * m_count && !found; k++) begin
            if (m_remaining[slot] != '0) found = 1'b1;
            else slot = next_slot(slot);
          end
          for (k = 0; k < m_count && !found; k++) begin
            if (m_remaining[k] != '0) begin
              slot = k;
              found = 1'b1;
            end
          end
          // An idle gap moves the clock to the arrival of the chosen task.
          if (m_clock < TIME_W'(m_arrival[slot])) m_clock = TIME_W'(m_arrival[slot]);
          rep.task_index = slot[TASK_INDEX_W-1:0];
          rep.slice_start = m_clock;
          q = (m_quantum == '0) ? TIME_W'(1) : TIME_W'(m_quantum);
          if (TIME_W'(m_remaining[slot]) <= q) begin
            len = TIME_W'(m_remaining[slot]);
            m_clock += len;
            m_remaining[slot] = '0;
            m_left--;
            tat = m_clock - TIME_W'(m_arrival[slot]);
            wt = tat - TIME_W'(m_burst[slot]);
            m_wait_sum += wt;
            m_tat_sum += tat;
            rep.task_finished = 1'b1;
            rep.wait_time = wt;
            rep.turnaround_time = tat;
            tasks_completed++;
          end else begin
            len = q;
            m_clock += q;
            m_remaining[slot] -= q[BURST_W-1:0];
          end
          rep.slice_length = len[BURST_W-1:0];
          m_cursor = next_slot(slot);
          slices_granted++;
        end
        if (m_left == 0 && m_count > 0) begin
          rep.all_done = 1'b1;
          rep.total_wait = m_wait_sum;
          rep.total_turnaround = m_tat_sum;
        end
      end
      default: begin
        // The unused op is dropped without a report.
      end
    endcase
  endtask

  function automatic string report_text(input slice_report_t r);
    return $sformatf({"slot %0d start %0d len %0d fin %0b wait %0d tat %0d ",
                      "done %0b twait %0d ttat %0d full %0b"},
                     r.task_index, r.slice_start, r.slice_length, r.task_finished,
                     r.wait_time, r.turnaround_time, r.all_done, r.total_wait,
                     r.total_turnaround, r.table_full);
  endfunction

  // Offer one item after a random gap and record its predicted report.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BURST_W-1:0] burst,
                           input logic [ARR_W-1:0] arrival);
    int unsigned gap;
    bit has_report;
    slice_report_t rep;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    burst_time_i <= burst;
    arrival_time_i <= arrival;
    do @(posedge clk_i); while (in_stall_o);
    schedule_model(op, burst, arrival, has_report, rep);
    if (has_report) pending_reports.push_back(rep);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering items until every predicted report has been transferred.
  task automatic wait_for_reports(input bit settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_reports.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Quantum is written only once the block has gone quiet.
  task automatic set_quantum(input logic [BURST_W-1:0] value);
    wait_for_reports(1'b1);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    m_quantum = value;
    quantum_writes++;
  endtask

  // One schedule: clear, a table of tasks, then up to 150 runs until every task is done, then one or two more.
  task automatic play_schedule(input int unsigned n_tasks, input bit pause_midway);
    int unsigned q_eff;
    int unsigned burst_top;
    int unsigned step_top;
    int unsigned runs;
    int unsigned k;
    longint unsigned arr;
    send_item(OP_CLEAR, BURST_W'($urandom), ARR_W'($urandom));
    q_eff = (m_quantum == '0) ? 1 : m_quantum;
    burst_top = q_eff * $urandom_range(1, 5);
    if (burst_top > 65535) burst_top = 65535;
    case ($urandom_range(0, 3))
      0: step_top = 0;
      1: step_top = 16;
      2: step_top = 4096;
      default: step_top = 1 << 20;
    endcase
    arr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ARR_MAX) : $urandom_range(0, 64);
    for (k = 0; k < n_tasks; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        // Loads out of arrival order are accepted as given.
        send_item(OP_LOAD, BURST_W'($urandom_range(0, burst_top)), ARR_W'($urandom));
      end else begin
        arr += $urandom_range(0, step_top);
        if (arr > ARR_MAX) arr = ARR_MAX;
        send_item(OP_LOAD, BURST_W'($urandom_range(0, burst_top)), ARR_W'(arr));
      end
    end
    runs = 0;
    while (m_left != 0 && runs < 150) begin
      if (pause_midway && runs == 4) wait_for_reports(1'b0);
      // Occasional noise between runs: an unused op or a late load.
      case ($urandom_range(0, 19))
        0: send_item(OP_UNUSED, BURST_W'($urandom), ARR_W'($urandom));
        1: send_item(OP_LOAD, BURST_W'($urandom_range(0, burst_top)), ARR_W'($urandom));
        default: begin
        end
      endcase
      send_item(OP_RUN, BURST_W'($urandom), ARR_W'($urandom));
      runs++;
    end
    repeat ($urandom_range(1, 2)) send_item(OP_RUN, BURST_W'($urandom), ARR_W'($urandom));
  endtask

  // Field extremes, every op, zero burst and quantum, idle gaps and fallback scan.
  task automatic test_directed();
    send_gap_max = 4;
    stall_max = 4;
    set_quantum(16'hFFFF);
    send_item(OP_RUN, '0, '0);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_LOAD, 16'd0, 24'd0);
    send_item(OP_LOAD, 16'hFFFF, 24'd5);
    send_item(OP_LOAD, 16'd3, ARR_MAX);
    // The second and third runs fall back to the lowest unfinished slot.
    repeat (4) send_item(OP_RUN, '0, '0);
    send_item(OP_LOAD, 16'd7, 24'd2);
    send_item(OP_RUN, '1, '1);
    send_item(OP_CLEAR, '1, '1);
    set_quantum(16'd0);
    send_item(OP_LOAD, 16'd2, 24'd0);
    repeat (3) send_item(OP_RUN, '0, '0);
  endtask

  // Fill the table past its size, then run it dry.
  task automatic test_table_full();
    send_item(OP_CLEAR, '0, '0);
    repeat (MAX_TASKS + 2) begin
      send_item(OP_LOAD, BURST_W'($urandom_range(0, 3)), '0);
    end
    while (m_left != 0) send_item(OP_RUN, BURST_W'($urandom), ARR_W'($urandom));
    send_item(OP_RUN, '0, '0);
  endtask

  // Smallest, largest and zero quantum; the largest one runs without idling.
  task automatic test_quantum_extremes();
    logic [BURST_W-1:0] extremes [3];
    extremes = '{16'd1, 16'hFFFF, 16'd0};
    foreach (extremes[i]) begin
      set_quantum(extremes[i]);
      send_gap_max = (extremes[i] == 16'hFFFF) ? 0 : 4;
      stall_max = send_gap_max;
      repeat (3) play_schedule($urandom_range(1, MAX_TASKS), 1'b0);
    end
    send_gap_max = 4;
    stall_max = 4;
  endtask

  // A long output hold-off fills the block; later the sender drains it fully.
  task automatic test_backpressure();
    send_gap_max = 0;
    hold_request = HOLD_CYCLES;
    play_schedule(12, 1'b0);
    send_gap_max = 4;
    play_schedule(10, 1'b1);
  endtask

  // Random quantum settings and random schedules up to the item budget.
  task automatic test_random_mix();
    int unsigned n;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: set_quantum(BURST_W'($urandom_range(1, 8)));
        1: set_quantum(BURST_W'($urandom_range(2, 64)));
        2: set_quantum(BURST_W'($urandom));
        default: set_quantum(QUANTUM_RESET);
      endcase
      repeat (5) begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(MAX_TASKS, MAX_TASKS + 2);
        else n = $urandom_range(1, 12);
        play_schedule(n, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Output side: a random stall after each transfer, plus the requested hold-off.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) stall_left = $urandom_range(0, stall_max);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each output transfer with the oldest predicted report.
  always @(posedge clk_i) begin : report_check
    slice_report_t got;
    slice_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{task_index_o, slice_start_o, slice_length_o, task_finished_o, wait_time_o,
              turnaround_time_o, all_done_o, total_wait_o, total_turnaround_o,
              table_full_o};
      reports_checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED) $display("unexpected report: %s", report_text(got));
      end else begin
        want = pending_reports.pop_front();
        if (got.task_index !== want.task_index || got.slice_start !== want.slice_start ||
            got.slice_length !== want.slice_length ||
            got.task_finished !== want.task_finished ||
            got.wait_time !== want.wait_time ||
            got.turnaround_time !== want.turnaround_time ||
            got.all_done !== want.all_done || got.total_wait !== want.total_wait ||
            got.total_turnaround !== want.total_turnaround ||
            got.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED) begin
            $display("report %0d mismatch at %0t", reports_checked, $realtime);
            $display("  expected: %s", report_text(want));
            $display("  actual:   %s", report_text(got));
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("round_robin_slice_scheduler test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_LOAD;
    burst_time_i = '0;
    arrival_time_i = '0;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_full();
    test_quantum_extremes();
    test_backpressure();
    test_random_mix();

    wait_for_reports(1'b1);
    $display("covered %0d items: %0d slices, %0d completions, %0d refused loads, %0d idle runs",
             items_sent, slices_granted, tasks_completed, refused_loads, empty_runs);
    $display("quantum set %0d times, %0d reports checked, %0d mismatches",
             quantum_writes, reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("round_robin_slice_scheduler test passed");
    end else begin
      $display("round_robin_slice_scheduler test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/rrss_pkg.sv
design/rrss_ram.sv
design/rrss_ctrl.sv
design/rrss_dpath.sv
design/round_robin_slice_scheduler.sv
test/round_robin_slice_scheduler_test.sv
